[src/iifd_pkg.sv]
`default_nettype none

package iifd_pkg;

    localparam int KIND_W   = 2;
    localparam int WORD_W   = 32;
    localparam int OPCODE_W = 11;
    localparam int REG_W    = 5;
    localparam int IMM_W    = 64;
    localparam int LOGIC_W  = 13;

    typedef enum logic [KIND_W-1:0] {
        KIND_ARITH = 2'd0,
        KIND_LOGIC = 2'd1,
        KIND_WIDE  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] instr_word;
    } item_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode_bits;
        logic [REG_W-1:0]    dest_reg;
        logic [REG_W-1:0]    src_reg;
        logic [IMM_W-1:0]    immediate;
    } result_t;

endpackage

`default_nettype wire

[src/iifd_instr_if.sv]
`default_nettype none

interface iifd_instr_if;
    import iifd_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [WORD_W-1:0]   instr_word;

    modport source (output valid, output kind, output instr_word, input ready);
    modport sink (input valid, input kind, input instr_word, output ready);
endinterface

`default_nettype wire

[src/iifd_decoded_if.sv]
`default_nettype none

interface iifd_decoded_if;
    import iifd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode_bits;
    logic [REG_W-1:0]      dest_reg;
    logic [REG_W-1:0]      src_reg;
    logic [IMM_W-1:0]      immediate;

    modport source (output valid, output opcode_bits, output dest_reg, output src_reg,
                    output immediate, input ready);
    modport sink (input valid, input opcode_bits, input dest_reg, input src_reg,
                  input immediate, output ready);
endinterface

`default_nettype wire

[src/immediate_instruction_field_decoder.sv]
`default_nettype none

// Items pass through the input register, then the result register, to the output
// channel. Throughput: one item per cycle while the output side is ready; the two
// registers form a two-stage pipeline whose ready follows the output side.
// Reset: asynchronous, active low; both stages come out of reset empty.
// Payload registers are not reset.

module immediate_instruction_field_decoder (
    input  wire logic clk,
    input  wire logic rst_n,
    iifd_instr_if.sink      instr,
    iifd_decoded_if.source  decoded
);
    import iifd_pkg::*;

    logic    item_valid_reg;
    item_t   item_reg;
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    result_load;
    logic    item_load;

    assign result_load = !result_valid_reg || decoded.ready;
    assign item_load   = !item_valid_reg || result_load;
    assign instr.ready = item_load;

    iifd_field_decode u_field_decode (
        .item   (item_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_load)
            begin
                item_valid_reg <= instr.valid;
            end
            if (result_load)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load && instr.valid)
        begin
            item_reg.kind       <= instr.kind;
            item_reg.instr_word <= instr.instr_word;
        end
        if (result_load && item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign decoded.valid       = result_valid_reg;
    assign decoded.opcode_bits = result_reg.opcode_bits;
    assign decoded.dest_reg    = result_reg.dest_reg;
    assign decoded.src_reg     = result_reg.src_reg;
    assign decoded.immediate   = result_reg.immediate;
endmodule

`default_nettype wire

[src/iifd_mask_expand.sv]
`default_nettype none

module iifd_mask_expand (
    input  wire logic [iifd_pkg::LOGIC_W-1:0] field,
    output logic [iifd_pkg::IMM_W-1:0]        mask
);
    import iifd_pkg::*;

    logic [6:0]        lead;
    logic              found;
    logic [5:0]        levels;
    logic [5:0]        s;
    logic [5:0]        r;
    logic [IMM_W-1:0]  ones;
    logic [IMM_W-1:0]  rep;
    logic [2*IMM_W-1:0] dbl;

    assign lead = {field[12], ~field[5:0]};

    // The element size is set by the highest one of N:NOT(imms).
    always_comb
    begin
        found  = 1'b0;
        levels = 6'd0;
        for (int i = 0; i < 7; i++)
        begin
            if (lead[i])
            begin
                found  = 1'b1;
                levels = 6'((7'd1 << i) - 7'd1);
            end
        end
    end

    assign s = field[5:0] & levels;
    assign r = field[11:6] & levels;

    // Replicating first and then rotating the whole word gives the same result,
    // since the element size divides 64.
    always_comb
    begin
        for (int b = 0; b < IMM_W; b++)
        begin
            ones[b] = (6'(b) <= s);
        end
        for (int b = 0; b < IMM_W; b++)
        begin
            rep[b] = ones[6'(b) & levels];
        end
    end

    assign dbl  = {rep, rep} >> r;
    assign mask = found ? dbl[IMM_W-1:0] : '0;
endmodule

`default_nettype wire

[src/iifd_field_decode.sv]
`default_nettype none

module iifd_field_decode (
    input  wire iifd_pkg::item_t   item,
    output iifd_pkg::result_t      result
);
    import iifd_pkg::*;

    logic [IMM_W-1:0] logic_mask;

    iifd_mask_expand u_mask_expand (
        .field (item.instr_word[22:10]),
        .mask  (logic_mask)
    );

    always_comb
    begin
        result = '0;
        unique case (kind_t'(item.kind))
            KIND_ARITH:
            begin
                result.opcode_bits = {1'b0, item.instr_word[31:22]};
                result.dest_reg    = item.instr_word[4:0];
                result.src_reg     = item.instr_word[9:5];
                result.immediate   = {52'd0, item.instr_word[21:10]};
            end
            KIND_LOGIC:
            begin
                result.opcode_bits = {2'b00, item.instr_word[31:23]};
                result.dest_reg    = item.instr_word[4:0];
                result.src_reg     = item.instr_word[9:5];
                result.immediate   = logic_mask;
            end
            KIND_WIDE:
            begin
                result.opcode_bits = item.instr_word[31:21];
                result.dest_reg    = item.instr_word[4:0];
                result.src_reg     = '0;
                result.immediate   = {48'd0, item.instr_word[20:5]};
            end
            default:
            begin
                result = '0;
            end
        endcase
    end
endmodule

`default_nettype wire
